FILE: rtl/core/preemptive_priority_scheduler_defines.svh
// assertion macros for the preemptive priority scheduler
// used by the top level only, no other dependencies
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pps_pkg.sv
// shared types, constants and helpers for the preemptive priority scheduler
// no dependencies
package pps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int PNUM_W    = 5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } t_in_item;

    typedef struct packed {
        logic              ran;
        logic [PNUM_W-1:0] proc_number;
        logic [31:0]       tick_time;
        logic              finished;
        logic [31:0]       finish_time;
        logic              all_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    function automatic logic [31:0] sat_inc(input logic [31:0] t);
        sat_inc = (t == TIME_MAX) ? TIME_MAX : t + 32'd1;
    endfunction

endpackage

FILE: rtl/core/pps_entry_mem.sv
// entry table: arrival, remaining burst and priority per process
// one write port, one read port with registered read data; uses pps_pkg
module pps_entry_mem (
    input  logic                      i_clk,
    input  pps_pkg::t_mem_wr          i_wr,
    input  logic [pps_pkg::IDX_W-1:0] i_raddr,
    output pps_pkg::t_entry           o_rdata
);
    import pps_pkg::*;

    t_entry r_mem [MAX_PROCS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/preemptive_priority_scheduler.sv
// Preemptive priority scheduler, top level.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes load, tick and clear
// items; output channel (o_out_valid / i_out_ready / o_out_data) gives one result
// per tick item. Load and clear items give no result.
// A load or clear is taken in the idle state and o_in_ready stays high, so they can follow
// back to back. A tick reads the entry table one entry a cycle through the single
// read port of the entry memory and compares each entry when its registered read
// data returns. It then writes back the picked entry and loads the output register,
// and only then is the next item accepted. The scan grows with the entry count.
// The result sits in an output register; a load or clear is still taken while
// it waits. A further tick scans, then holds in its final step, with the input
// channel blocked, until the waiting result is taken.
// Reset (synchronous, active low) empties the table, sets time to zero and
// drops o_out_valid. The table memory itself is not cleared; entries are only
// read below the fill count.
module preemptive_priority_scheduler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pps_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pps_pkg::t_out_item o_out_data
);
    import pps_pkg::*;
    `include "preemptive_priority_scheduler_defines.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_now;
    logic [CNT_W-1:0] r_idx;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_pick;
    t_entry           r_best;
    logic [CNT_W-1:0] r_nz;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_fire;
    logic             issue;
    logic             eligible;
    logic             better;
    logic             out_free;
    logic [15:0]      new_rem;
    logic             fin;
    logic [CNT_W-1:0] nz_after;
    logic [CNT_W-1:0] pnum_full;
    t_mem_wr          mem_wr;
    t_entry           rd_data;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // scan: one read issued per cycle, compared the cycle after
    assign issue    = (r_state == ST_SCAN) && (r_idx < r_count);
    assign eligible = r_pend && (32'(rd_data.arrival) <= r_now) && (rd_data.remaining != 16'd0);
    assign better   = eligible && (!r_found || (rd_data.prio < r_best.prio));

    assign new_rem   = r_best.remaining - 16'd1;
    assign fin       = r_found && (new_rem == 16'd0);
    assign nz_after  = r_nz - (fin ? CNT_W'(1) : CNT_W'(0));
    assign pnum_full = CNT_W'(r_pick) + CNT_W'(1);

    always_comb begin
        mem_wr = '0;
        if (r_state == ST_DONE) begin
            mem_wr.we             = out_free && r_found;
            mem_wr.addr           = r_pick;
            mem_wr.data           = r_best;
            mem_wr.data.remaining = new_rem;
        end else begin
            mem_wr.we        = in_fire && (i_in_data.operation == OP_LOAD)
                               && (r_count < CNT_W'(MAX_PROCS));
            mem_wr.addr      = r_count[IDX_W-1:0];
            mem_wr.data      = '{arrival: i_in_data.arrival, remaining: i_in_data.burst,
                                 prio: i_in_data.prio};
        end
    end

    pps_entry_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_in_data.operation == OP_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_pend <= 1'b0;
                    if (in_fire) begin
                        case (i_in_data.operation)
                            OP_LOAD: begin
                                if (r_count < CNT_W'(MAX_PROCS)) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_now   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    r_pend <= issue;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_now       <= sat_inc(r_now);
                    end
                end
                default: ;
            endcase
        end
    end

    // scan bookkeeping and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_idx   <= '0;
                r_found <= 1'b0;
                r_nz    <= '0;
            end
            ST_SCAN: begin
                r_pend_idx <= r_idx[IDX_W-1:0];
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (better) begin
                    r_found <= 1'b1;
                    r_pick  <= r_pend_idx;
                    r_best  <= rd_data;
                end
                if (r_pend && (rd_data.remaining != 16'd0)) begin
                    r_nz <= r_nz + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out.ran         <= r_found;
                    r_out.proc_number <= r_found ? PNUM_W'(pnum_full) : '0;
                    r_out.tick_time   <= r_now;
                    r_out.finished    <= fin;
                    r_out.finish_time <= fin ? sat_inc(r_now) : '0;
                    r_out.all_done    <= (nz_after == '0);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PPS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_PROCS), "entry count beyond table")
    `PPS_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, r_state == ST_SCAN,
        r_idx <= r_count, "scan ran past fill count")
    `PPS_ASSERT_NOW(a_ran_pnum, i_clk, i_rst_n, o_out_valid,
        o_out_data.ran == (o_out_data.proc_number != '0), "ran and entry number disagree")
    `PPS_ASSERT_NOW(a_fin_ran, i_clk, i_rst_n, o_out_valid && o_out_data.finished,
        o_out_data.ran, "finish reported on idle tick")
    `PPS_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, (r_state == ST_DONE) && out_free,
        o_out_valid && (r_state == ST_IDLE), "tick result not presented")

endmodule

FILE: bench/preemptive_priority_scheduler_tb.sv
// self-checking bench for the preemptive priority scheduler: directed and random load/tick/clear
// items, predicted in-bench and compared field by field on the result channel
// depends on pps_pkg and the preemptive_priority_scheduler top level only
module preemptive_priority_scheduler_tb;
    import pps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_in_item in_data = '0;
    logic in_ready;
    logic out_valid;
    t_out_item out_data;

    t_in_item pending_items[$];
    t_out_item owed_reports[$];
    int mismatches = 0;
    int items_taken = 0;
    int cycles = 0;
    logic calm;

    // bench copy of the process table
    logic [15:0] arr_tab[MAX_PROCS];
    logic [15:0] rem_tab[MAX_PROCS];
    logic [7:0] pri_tab[MAX_PROCS];
    int fill = 0;
    logic [31:0] clock_now = '0;

    always #10 i_clk = ~i_clk;

    preemptive_priority_scheduler DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    // no idling on either side over a long middle stretch
    assign calm = (items_taken >= 150) && (items_taken < 300);

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < 100) begin
            $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
        end
        mismatches++;
    endtask

    function automatic void queue_item(input logic [1:0] op, input logic [15:0] arr,
                                       input logic [15:0] bur, input logic [7:0] pri);
        t_in_item it;
        it.operation = op;
        it.arrival = arr;
        it.burst = bur;
        it.prio = pri;
        pending_items.push_back(it);
    endfunction

    task automatic advance_schedule(input t_in_item it);
        int pick;
        bit found;
        bit every_done;
        logic [7:0] best;
        logic [31:0] t;
        t_out_item r;
        pick = 0;
        found = 1'b0;
        every_done = 1'b1;
        best = '0;
        case (it.operation)
            OP_LOAD: begin
                if (fill < MAX_PROCS) begin
                    arr_tab[fill] = it.arrival;
                    rem_tab[fill] = it.burst;
                    pri_tab[fill] = it.prio;
                    fill++;
                end
            end
            OP_CLEAR: begin
                fill = 0;
                clock_now = '0;
            end
            OP_TICK: begin
                t = clock_now;
                // strict less-than keeps the earlier entry on equal priority
                for (int i = 0; i < fill; i++) begin
                    if ({16'd0, arr_tab[i]} <= t && rem_tab[i] != 16'd0) begin
                        if (!found || pri_tab[i] < best) begin
                            best = pri_tab[i];
                            pick = i;
                            found = 1'b1;
                        end
                    end
                end
                r = '0;
                r.tick_time = t;
                if (found) begin
                    rem_tab[pick] = rem_tab[pick] - 16'd1;
                    r.ran = 1'b1;
                    r.proc_number = PNUM_W'(pick + 1);
                    if (rem_tab[pick] == 16'd0) begin
                        r.finished = 1'b1;
                        r.finish_time = (t == TIME_MAX) ? TIME_MAX : t + 32'd1;
                    end
                end
                for (int i = 0; i < fill; i++) begin
                    if (rem_tab[i] != 16'd0) every_done = 1'b0;
                end
                r.all_done = every_done;
                clock_now = (t == TIME_MAX) ? TIME_MAX : t + 32'd1;
                owed_reports.push_back(r);
            end
            default: ;
        endcase
    endtask

    // driver: presents the next pending item, holding it until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                advance_schedule(in_data);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each taken result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (owed_reports.size() == 0) begin
                    note_mismatch("unexpected result, tick_time", out_data.tick_time, '0);
                end else begin
                    want = owed_reports.pop_front();
                    if (out_data.ran !== want.ran)
                        note_mismatch("ran", out_data.ran, want.ran);
                    if (out_data.proc_number !== want.proc_number)
                        note_mismatch("proc_number", out_data.proc_number, want.proc_number);
                    if (out_data.tick_time !== want.tick_time)
                        note_mismatch("tick_time", out_data.tick_time, want.tick_time);
                    if (out_data.finished !== want.finished)
                        note_mismatch("finished", out_data.finished, want.finished);
                    if (out_data.finish_time !== want.finish_time)
                        note_mismatch("finish_time", out_data.finish_time, want.finish_time);
                    if (out_data.all_done !== want.all_done)
                        note_mismatch("all_done", out_data.all_done, want.all_done);
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d items pending, %0d results owed",
                     pending_items.size(), owed_reports.size());
            $display("preemptive_priority_scheduler_tb: FAIL");
            $finish;
        end
    end

    initial begin
        int n_loads;
        int n_ticks;
        bit wide;
        // empty table: idle tick reports all done
        queue_item(OP_CLEAR, '0, '0, '0);
        queue_item(OP_TICK, '0, '0, '0);
        // zero burst entry, extremes of the fields, one that never arrives
        queue_item(OP_LOAD, 16'd0, 16'd0, 8'd0);
        queue_item(OP_LOAD, 16'd0, 16'd2, 8'hFF);
        queue_item(OP_LOAD, 16'd1, 16'd1, 8'd0);
        queue_item(OP_LOAD, 16'hFFFF, 16'hFFFF, 8'h80);
        queue_item(OP_UNUSED, 16'($urandom()), 16'($urandom()), 8'($urandom()));
        repeat (5) queue_item(OP_TICK, 16'($urandom()), 16'($urandom()), 8'($urandom()));
        // full table, the last load is dropped; equal priorities tie toward the earlier entry
        queue_item(OP_CLEAR, '0, '0, '0);
        for (int i = 0; i < MAX_PROCS + 1; i++) begin
            queue_item(OP_LOAD, 16'd0, 16'd1, 8'(i % 2));
        end
        repeat (3) queue_item(OP_TICK, '0, '0, '0);

        // random scenarios: load a set, then tick through it with a little noise
        while (pending_items.size() < 530) begin
            if ($urandom_range(0, 4) != 0) queue_item(OP_CLEAR, '0, '0, '0);
            n_loads = $urandom_range(1, MAX_PROCS + 1);
            for (int i = 0; i < n_loads; i++) begin
                wide = ($urandom_range(0, 7) == 0);
                queue_item(OP_LOAD,
                           wide ? 16'($urandom()) : 16'($urandom_range(0, 30)),
                           wide ? 16'($urandom()) : 16'($urandom_range(0, 6)),
                           wide ? 8'($urandom()) : 8'($urandom_range(0, 7)));
            end
            n_ticks = $urandom_range(10, 40);
            for (int i = 0; i < n_ticks; i++) begin
                case ($urandom_range(0, 19))
                    0: queue_item(OP_UNUSED, 16'($urandom()), 16'($urandom()), 8'($urandom()));
                    // late arrival while others run, may preempt
                    1: queue_item(OP_LOAD, 16'($urandom_range(0, 40)),
                                  16'($urandom_range(1, 5)), 8'($urandom_range(0, 7)));
                    default: queue_item(OP_TICK, 16'($urandom()), 16'($urandom()),
                                        8'($urandom()));
                endcase
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_items.size() > 0 || in_valid || owed_reports.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("preemptive_priority_scheduler_tb: PASS");
        end else begin
            $display("preemptive_priority_scheduler_tb: FAIL");
        end
        $finish;
    end

endmodule
